/* rtl/bptc_pkg.sv */
// shared types, constants and helpers for the barometric compensation block
`default_nettype none

package bptc_pkg;

	localparam int unsigned RAW_W      = 24;
	localparam int unsigned CAL_W      = 16;
	localparam int unsigned NUM_CAL    = 6;
	localparam int unsigned CIDX_W     = 3;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned OUT_T_W    = 15;
	localparam int unsigned OUT_P_W    = 17;

	localparam int unsigned MUL_W      = 26;
	localparam int unsigned PROD_W     = 2 * MUL_W;
	localparam int unsigned DT_W       = RAW_W + 1;
	localparam int unsigned TEMP_W     = 20;
	localparam int unsigned ACC_W      = 44;
	localparam int unsigned WIDE_W     = 63;
	localparam int unsigned PRES_W     = 28;
	localparam int unsigned SENS_SPLIT = 19;

	localparam int unsigned SH_C5   = 8;
	localparam int unsigned SH_C2   = 16;
	localparam int unsigned SH_C1   = 15;
	localparam int unsigned SH_TEMP = 23;
	localparam int unsigned SH_OFF  = 7;
	localparam int unsigned SH_SENS = 8;
	localparam int unsigned SH_T2   = 31;
	localparam int unsigned SH_P    = 21;
	localparam int unsigned SH_OUT  = 15;

	localparam int unsigned CAL_PSENS  = 0;
	localparam int unsigned CAL_POFF   = 1;
	localparam int unsigned CAL_TCS    = 2;
	localparam int unsigned CAL_TCO    = 3;
	localparam int unsigned CAL_TREF   = 4;
	localparam int unsigned CAL_TSLOPE = 5;

	localparam logic signed [TEMP_W-1:0] TEMP_REF = TEMP_W'(2000);
	localparam logic signed [TEMP_W-1:0] TEMP_LOW = TEMP_W'(-1500);
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = TEMP_W'(-4000);
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = TEMP_W'(8500);
	localparam logic signed [PRES_W-1:0] PRES_MIN = PRES_W'(1000);
	localparam logic signed [PRES_W-1:0] PRES_MAX = PRES_W'(120000);

	typedef logic [CAL_W-1:0] cal_word_t;
	typedef cal_word_t [NUM_CAL-1:0] cal_set_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_ZERO  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DT,
		ST_MT,
		ST_MO,
		ST_MS,
		ST_MD,
		ST_MA,
		ST_MB,
		ST_CORR,
		ST_APPLY,
		ST_PL,
		ST_PH,
		ST_PX,
		ST_PY,
		ST_PZ,
		ST_FIN,
		ST_CHK,
		ST_DONE
	} step_t;

	typedef struct packed {
		step_t step;
		logic  ready;
		logic  accept;
	} ctl_t;

	// signed division by 2^k, truncating toward zero
	function automatic logic signed [63:0] div_pow2(input logic signed [63:0] v,
			input int unsigned k);
		logic signed [63:0] bias;
		bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (v + bias) >>> k;
	endfunction

endpackage

`default_nettype wire

/* rtl/bptc_if.sv */
// sample, result and configuration channels of the compensation block
`default_nettype none

interface bptc_sample_if;
	logic                          valid;
	logic                          ready;
	logic [bptc_pkg::RAW_W-1:0]    raw_pressure;
	logic [bptc_pkg::RAW_W-1:0]    raw_temperature;

	modport source (output valid, raw_pressure, raw_temperature, input ready);
	modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bptc_result_if;
	logic                               valid;
	logic                               ready;
	logic [bptc_pkg::STAT_W-1:0]        status;
	logic signed [bptc_pkg::OUT_T_W-1:0] temperature_centideg;
	logic [bptc_pkg::OUT_P_W-1:0]       pressure_pa;

	modport source (output valid, status, temperature_centideg, pressure_pa, input ready);
	modport sink (input valid, status, temperature_centideg, pressure_pa, output ready);
endinterface

interface bptc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bptc_pkg::CIDX_W-1:0]   index;
	logic [bptc_pkg::CAL_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/baro_pressure_temp_compensation_unit.sv */
// top level of the barometric pressure and temperature compensation block
// a request with both raw values nonzero runs the temperature, offset, sensitivity,
// correction and pressure steps; a zero raw value sends it straight to the result step
// a new request is taken only in idle; the steps use the sequenced 26 x 26 shared multiplier
// the output register lets a finished result wait while the next request is taken
// reset clears calibration words, held values, the sequencer and the result valid
`default_nettype none

module baro_pressure_temp_compensation_unit (
	input wire logic       clk,
	input wire logic       arst_n,
	bptc_sample_if.sink    sample,
	bptc_result_if.source  result,
	bptc_cfg_if.sink       cfg
);

	bptc_pkg::cal_set_t cal_q;
	bptc_pkg::ctl_t     ctl;
	logic               zero;
	logic               out_free;

	assign cfg.ready    = 1'b1;
	assign sample.ready = ctl.ready;
	assign zero = (sample.raw_pressure == '0) || (sample.raw_temperature == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg.valid && (cfg.index < bptc_pkg::CIDX_W'(bptc_pkg::NUM_CAL))) begin
			cal_q[cfg.index] <= cfg.data;
		end
	end

	bptc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sample.valid),
		.zero     (zero),
		.out_free (out_free),
		.ctl      (ctl)
	);

	bptc_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.ctl                  (ctl),
		.zero                 (zero),
		.raw_pressure         (sample.raw_pressure),
		.raw_temperature      (sample.raw_temperature),
		.cal                  (cal_q),
		.out_ready            (result.ready),
		.out_valid            (result.valid),
		.out_free             (out_free),
		.status               (result.status),
		.temperature_centideg (result.temperature_centideg),
		.pressure_pa          (result.pressure_pa)
	);

endmodule

`default_nettype wire

/* rtl/bptc_mul.sv */
// shared signed multiplier with registered product
`default_nettype none

module bptc_mul (
	input  wire logic                                clk,
	input  wire logic signed [bptc_pkg::MUL_W-1:0]   a,
	input  wire logic signed [bptc_pkg::MUL_W-1:0]   b,
	output logic signed [bptc_pkg::PROD_W-1:0]       p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

`default_nettype wire

/* rtl/bptc_seq.sv */
// step sequencer of the compensation block
`default_nettype none

module bptc_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          zero,
	input  wire logic          out_free,
	output bptc_pkg::ctl_t     ctl
);

	bptc_pkg::step_t step_q;
	bptc_pkg::step_t step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bptc_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctl.step   = step_q;
		ctl.ready  = (step_q == bptc_pkg::ST_IDLE);
		ctl.accept = ctl.ready && start;
		case (step_q)
			bptc_pkg::ST_IDLE: begin
				if (start) begin
					step_d = zero ? bptc_pkg::ST_DONE : bptc_pkg::ST_DT;
				end else begin
					step_d = bptc_pkg::ST_IDLE;
				end
			end
			bptc_pkg::ST_DT:    step_d = bptc_pkg::ST_MT;
			bptc_pkg::ST_MT:    step_d = bptc_pkg::ST_MO;
			bptc_pkg::ST_MO:    step_d = bptc_pkg::ST_MS;
			bptc_pkg::ST_MS:    step_d = bptc_pkg::ST_MD;
			bptc_pkg::ST_MD:    step_d = bptc_pkg::ST_MA;
			bptc_pkg::ST_MA:    step_d = bptc_pkg::ST_MB;
			bptc_pkg::ST_MB:    step_d = bptc_pkg::ST_CORR;
			bptc_pkg::ST_CORR:  step_d = bptc_pkg::ST_APPLY;
			bptc_pkg::ST_APPLY: step_d = bptc_pkg::ST_PL;
			bptc_pkg::ST_PL:    step_d = bptc_pkg::ST_PH;
			bptc_pkg::ST_PH:    step_d = bptc_pkg::ST_PX;
			bptc_pkg::ST_PX:    step_d = bptc_pkg::ST_PY;
			bptc_pkg::ST_PY:    step_d = bptc_pkg::ST_PZ;
			bptc_pkg::ST_PZ:    step_d = bptc_pkg::ST_FIN;
			bptc_pkg::ST_FIN:   step_d = bptc_pkg::ST_CHK;
			bptc_pkg::ST_CHK:   step_d = bptc_pkg::ST_DONE;
			bptc_pkg::ST_DONE: begin
				step_d = out_free ? bptc_pkg::ST_IDLE : bptc_pkg::ST_DONE;
			end
			default:            step_d = bptc_pkg::ST_IDLE;
		endcase
	end

	a_nonzero_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && !zero) |=> (step_q == bptc_pkg::ST_DT))
		else $error("nonzero request did not start the computation");

	a_zero_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && zero) |=> (step_q == bptc_pkg::ST_DONE))
		else $error("zero request did not go straight to the result");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == bptc_pkg::ST_DONE && !out_free) |=> (step_q == bptc_pkg::ST_DONE))
		else $error("result step left while output register full");

endmodule

`default_nettype wire

/* rtl/bptc_dp.sv */
// fixed-point datapath, held values and result register
`default_nettype none

module bptc_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire bptc_pkg::ctl_t                       ctl,
	input  wire logic                                 zero,
	input  wire logic [bptc_pkg::RAW_W-1:0]           raw_pressure,
	input  wire logic [bptc_pkg::RAW_W-1:0]           raw_temperature,
	input  wire bptc_pkg::cal_set_t                   cal,
	input  wire logic                                 out_ready,
	output logic                                      out_valid,
	output logic                                      out_free,
	output logic [bptc_pkg::STAT_W-1:0]               status,
	output logic signed [bptc_pkg::OUT_T_W-1:0]       temperature_centideg,
	output logic [bptc_pkg::OUT_P_W-1:0]              pressure_pa
);

	localparam int unsigned MW  = bptc_pkg::MUL_W;
	localparam int unsigned PW  = bptc_pkg::PROD_W;
	localparam int unsigned DW  = bptc_pkg::DT_W;
	localparam int unsigned TW  = bptc_pkg::TEMP_W;
	localparam int unsigned AW  = bptc_pkg::ACC_W;
	localparam int unsigned WW  = bptc_pkg::WIDE_W;
	localparam int unsigned RW  = bptc_pkg::PRES_W;
	localparam int unsigned CW  = bptc_pkg::CAL_W;
	localparam int unsigned SPL = bptc_pkg::SENS_SPLIT;

	logic [bptc_pkg::RAW_W-1:0]   d1_q;
	logic [bptc_pkg::RAW_W-1:0]   d2_q;
	logic signed [DW-1:0]         dt_q;
	logic signed [TW-1:0]         temp_q;
	logic signed [TW-1:0]         t2_q;
	logic signed [AW-1:0]         off_q;
	logic signed [AW-1:0]         sens_q;
	logic signed [AW-1:0]         off2_q;
	logic signed [AW-1:0]         sens2_q;
	logic signed [AW-1:0]         x_q;
	logic [PW-1:0]                lo_q;
	logic signed [WW-1:0]         wide_q;
	logic signed [RW-1:0]         pres_q;
	bptc_pkg::status_t            status_q;
	logic signed [bptc_pkg::OUT_T_W-1:0] held_t_q;
	logic [bptc_pkg::OUT_P_W-1:0] held_p_q;
	logic                         out_valid_q;
	bptc_pkg::status_t            out_stat_q;
	logic signed [bptc_pkg::OUT_T_W-1:0] out_t_q;
	logic [bptc_pkg::OUT_P_W-1:0] out_p_q;

	logic signed [MW-1:0]         mul_a;
	logic signed [MW-1:0]         mul_b;
	logic signed [PW-1:0]         prod;
	logic signed [63:0]           prod64;
	logic signed [63:0]           wide64;
	logic signed [63:0]           x64;
	logic signed [63:0]           q_temp;
	logic signed [63:0]           q_off;
	logic signed [63:0]           q_sens;
	logic signed [63:0]           q_p;
	logic signed [63:0]           q_out;
	logic signed [TW-1:0]         a_val;
	logic signed [TW-1:0]         b_val;
	logic signed [AW-1:0]         sq;
	logic signed [AW-1:0]         sq5;
	logic signed [AW-1:0]         sq7;
	logic signed [AW-1:0]         sq11;
	logic signed [DW-1:0]         dt_new;
	logic                         temp_ok;
	logic                         pres_ok;
	logic                         load_out;

	bptc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	always_comb begin
		a_val  = temp_q - bptc_pkg::TEMP_REF;
		b_val  = temp_q - bptc_pkg::TEMP_LOW;
		prod64 = {{(64-PW){prod[PW-1]}}, prod};
		wide64 = {{(64-WW){wide_q[WW-1]}}, wide_q};
		x64    = {{(64-AW){x_q[AW-1]}}, x_q};
		q_temp = bptc_pkg::div_pow2(prod64, bptc_pkg::SH_TEMP);
		q_off  = bptc_pkg::div_pow2(prod64, bptc_pkg::SH_OFF);
		q_sens = bptc_pkg::div_pow2(prod64, bptc_pkg::SH_SENS);
		q_p    = bptc_pkg::div_pow2(wide64, bptc_pkg::SH_P);
		q_out  = bptc_pkg::div_pow2(x64, bptc_pkg::SH_OUT);
		sq     = prod[AW-1:0];
		sq5    = {sq[AW-3:0], 2'b0} + sq;
		sq7    = {sq[AW-4:0], 3'b0} - sq;
		sq11   = {sq[AW-4:0], 3'b0} + {sq[AW-2:0], 1'b0} + sq;
		dt_new = $signed({1'b0, d2_q})
			- $signed({1'b0, cal[bptc_pkg::CAL_TREF], {bptc_pkg::SH_C5{1'b0}}});
		temp_ok = (temp_q > bptc_pkg::TEMP_MIN) && (temp_q < bptc_pkg::TEMP_MAX);
		pres_ok = (pres_q > bptc_pkg::PRES_MIN) && (pres_q < bptc_pkg::PRES_MAX);
		out_free = !out_valid_q || out_ready;
		load_out = (ctl.step == bptc_pkg::ST_DONE) && out_free;
	end

	// operand selection for the shared multiplier
	always_comb begin
		case (ctl.step)
			bptc_pkg::ST_MT: begin
				mul_a = {{(MW-DW){dt_q[DW-1]}}, dt_q};
				mul_b = MW'(cal[bptc_pkg::CAL_TSLOPE]);
			end
			bptc_pkg::ST_MO: begin
				mul_a = MW'(cal[bptc_pkg::CAL_TCO]);
				mul_b = {{(MW-DW){dt_q[DW-1]}}, dt_q};
			end
			bptc_pkg::ST_MS: begin
				mul_a = MW'(cal[bptc_pkg::CAL_TCS]);
				mul_b = {{(MW-DW){dt_q[DW-1]}}, dt_q};
			end
			bptc_pkg::ST_MD: begin
				mul_a = {{(MW-DW){dt_q[DW-1]}}, dt_q};
				mul_b = {{(MW-DW){dt_q[DW-1]}}, dt_q};
			end
			bptc_pkg::ST_MA: begin
				mul_a = {{(MW-TW){a_val[TW-1]}}, a_val};
				mul_b = {{(MW-TW){a_val[TW-1]}}, a_val};
			end
			bptc_pkg::ST_MB: begin
				mul_a = {{(MW-TW){b_val[TW-1]}}, b_val};
				mul_b = {{(MW-TW){b_val[TW-1]}}, b_val};
			end
			bptc_pkg::ST_PL: begin
				mul_a = MW'(d1_q);
				mul_b = MW'(sens_q[SPL-1:0]);
			end
			bptc_pkg::ST_PH: begin
				mul_a = MW'(d1_q);
				mul_b = {{(MW-(AW-SPL)){sens_q[AW-1]}}, sens_q[AW-1:SPL]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctl.step)
			bptc_pkg::ST_IDLE: begin
				if (ctl.accept) begin
					d1_q <= raw_pressure;
					d2_q <= raw_temperature;
				end
			end
			bptc_pkg::ST_DT: dt_q <= dt_new;
			bptc_pkg::ST_MO: temp_q <= bptc_pkg::TEMP_REF + q_temp[TW-1:0];
			bptc_pkg::ST_MS: begin
				off_q <= AW'({cal[bptc_pkg::CAL_POFF], {bptc_pkg::SH_C2{1'b0}}})
					+ q_off[AW-1:0];
			end
			bptc_pkg::ST_MD: begin
				sens_q <= AW'({cal[bptc_pkg::CAL_PSENS], {bptc_pkg::SH_C1{1'b0}}})
					+ q_sens[AW-1:0];
			end
			bptc_pkg::ST_MA: t2_q <= TW'(prod >>> bptc_pkg::SH_T2);
			bptc_pkg::ST_MB: begin
				off2_q  <= sq5 >>> 1;
				sens2_q <= sq5 >>> 2;
			end
			bptc_pkg::ST_CORR: begin
				if (temp_q < bptc_pkg::TEMP_LOW) begin
					off2_q  <= off2_q + sq7;
					sens2_q <= sens2_q + (sq11 >>> 1);
				end
			end
			bptc_pkg::ST_APPLY: begin
				if (temp_q < bptc_pkg::TEMP_REF) begin
					temp_q <= temp_q - t2_q;
					off_q  <= off_q - off2_q;
					sens_q <= sens_q - sens2_q;
				end
			end
			bptc_pkg::ST_PH: lo_q <= prod;
			bptc_pkg::ST_PX: begin
				wide_q <= {prod[WW-SPL-1:0], {SPL{1'b0}}} + WW'(lo_q);
			end
			bptc_pkg::ST_PY: x_q <= q_p[AW-1:0];
			bptc_pkg::ST_PZ: x_q <= x_q - off_q;
			bptc_pkg::ST_FIN: pres_q <= q_out[RW-1:0];
			default: begin
			end
		endcase
	end

	// status, held values and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= bptc_pkg::STAT_OK;
			held_t_q    <= '0;
			held_p_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				status_q <= zero ? bptc_pkg::STAT_ZERO : bptc_pkg::STAT_OK;
			end
			if (ctl.step == bptc_pkg::ST_CHK) begin
				if (temp_ok && pres_ok) begin
					held_t_q <= temp_q[bptc_pkg::OUT_T_W-1:0];
					held_p_q <= pres_q[bptc_pkg::OUT_P_W-1:0];
				end else begin
					status_q <= bptc_pkg::STAT_RANGE;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_stat_q <= status_q;
			out_t_q    <= held_t_q;
			out_p_q    <= held_p_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign status               = out_stat_q;
	assign temperature_centideg = out_t_q;
	assign pressure_pa          = out_p_q;

	a_held_changes_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(held_p_q) |-> $past(ctl.step == bptc_pkg::ST_CHK))
		else $error("held pressure changed outside the check step");

	a_held_temp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		($signed(held_t_q) > -15'sd4000) && ($signed(held_t_q) < 15'sd8500))
		else $error("held temperature out of range");

	a_zero_status_source: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && status_q == bptc_pkg::STAT_ZERO) |-> (d1_q == '0 || d2_q == '0))
		else $error("zero status without a zero raw value");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.step == bptc_pkg::ST_DONE))
		else $error("result shown without the result step");

endmodule

`default_nettype wire
